// ===== rtl/core/vertex_index_dedup_assert.svh =====
// Assertion macros for the vertex index deduplicator.
// Each macro checks one property on the rising edge of i_clk and is
// switched off while i_rst_n is low.
`ifndef VERTEX_INDEX_DEDUP_ASSERT_SVH
`define VERTEX_INDEX_DEDUP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define VID_ASSERT_NOW(label, ante, cons, msg)
`define VID_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/vid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vid_pkg;

    // Table geometry.
    localparam int MAX_VERTICES = 1024;
    localparam int SLOT_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int INDEX_BITS   = 20;
    localparam int KEY_W        = 3 * INDEX_BITS;

    // Fixed field widths of the transactions.
    localparam int FIELD_W = 20;
    localparam int VIDX_W  = 10;

    typedef struct packed {
        logic               start_mesh;
        logic [FIELD_W-1:0] position_index;
        logic [FIELD_W-1:0] texcoord_index;
        logic [FIELD_W-1:0] normal_index;
    } t_in_item;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              overflow;
    } t_out_item;

    // Token that walks the cell chain, one cell per cycle while the chain advances.
    typedef struct packed {
        logic              valid;
        logic              clr;
        logic              done;
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_token;

endpackage

`default_nettype wire

// ===== rtl/core/vid_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vid_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  wire [vid_pkg::SLOT_W-1:0] i_slot,
    input  wire vid_pkg::t_token i_tok,
    output vid_pkg::t_token      o_tok,
    output logic                 o_occ
);
    import vid_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_occ;
    logic             n_occ;
    t_token           r_tok;
    t_token           n_tok;
    logic             occ_eff;
    logic             hit;
    logic             take;

    // A mesh start empties this slot before the compare.
    always_comb begin
        occ_eff = r_occ && !i_tok.clr;
        hit     = i_tok.valid && !i_tok.done && occ_eff && (r_key == i_tok.key);
        take    = i_tok.valid && !i_tok.done && !occ_eff;

        n_tok = i_tok;
        if (hit || take) begin
            n_tok.done = 1'b1;
            n_tok.slot = i_slot;
        end
        if (take) begin
            n_tok.is_new = 1'b1;
        end

        n_occ = r_occ;
        if (i_tok.valid) begin
            n_occ = occ_eff || take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '0;
        end else if (i_adv) begin
            r_occ <= n_occ;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && take) begin
            r_key <= i_tok.key;
        end
    end

    assign o_tok = r_tok;
    assign o_occ = r_occ;

endmodule

`default_nettype wire

// ===== rtl/core/vid_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vid_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire vid_pkg::t_token i_tok,
    input  wire                 i_out_stall,
    output logic                o_adv,
    output logic                o_out_valid,
    output vid_pkg::t_out_item  o_out_data
);
    import vid_pkg::*;

    logic      r_valid;
    t_out_item r_data;
    t_out_item n_data;

    // Advance whenever the result register is empty or being drained.
    assign o_adv = !r_valid || !i_out_stall;

    // A token that left the chain unresolved found the table full.
    always_comb begin
        n_data.vertex_index = i_tok.done ? VIDX_W'(i_tok.slot) : '0;
        n_data.is_new       = i_tok.done && i_tok.is_new;
        n_data.overflow     = !i_tok.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_tok.valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_index_dedup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Valid         Stall         Payload
// input     in         i_in_valid    o_in_stall    i_in_data  (t_in_item)
// output    out        o_out_valid   i_out_stall   o_out_data (t_out_item)
//
// A corner passes one register per cell of the chain and then the result
// register. A new corner enters every cycle while the chain moves.
// The whole chain holds while the result register is full and stalled.
// Reset (synchronous, active low) empties the table and the chain.
// o_in_stall follows i_out_stall through the result register only.

module vertex_index_dedup (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire vid_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output vid_pkg::t_out_item  o_out_data
);
    import vid_pkg::*;

    // Each cell owns one table slot. A corner travels down the chain as a
    // token; the first cell holding an equal triple resolves it as a hit,
    // and the first empty cell it reaches stores it as a new vertex. Tokens
    // follow one another in order, so every token sees all appends and
    // clears made by the tokens ahead of it. A mesh start token empties
    // each slot it passes, and therefore always lands in slot zero.
    t_token                  w_head;
    t_token                  w_tok [MAX_VERTICES+1];
    logic [MAX_VERTICES-1:0] w_occ;
    logic                    w_adv;

    // Build the head token; cut each index to the table key width.
    always_comb begin
        w_head.valid  = i_in_valid;
        w_head.clr    = i_in_data.start_mesh;
        w_head.done   = 1'b0;
        w_head.is_new = 1'b0;
        w_head.slot   = '0;
        w_head.key    = {i_in_data.normal_index[INDEX_BITS-1:0],
                         i_in_data.texcoord_index[INDEX_BITS-1:0],
                         i_in_data.position_index[INDEX_BITS-1:0]};
    end

    assign w_tok[0]   = w_head;
    assign o_in_stall = !w_adv;

    // One cell per slot; the slot number is wired in as a constant.
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        vid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_slot  (SLOT_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_occ   (w_occ[g])
        );
    end

    // Result register at the tail; it also sets the chain's advance.
    vid_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok[MAX_VERTICES]),
        .i_out_stall (i_out_stall),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`include "vertex_index_dedup_assert.svh"

    // An overflow result never appends and always reads slot zero.
    `VID_ASSERT_NOW(a_ovf_clean, o_out_valid && o_out_data.overflow, !o_out_data.is_new && (o_out_data.vertex_index == '0), "overflow result carries new flag or nonzero index")

    // Slot zero fills first, so an occupied last slot implies slot zero is used.
    `VID_ASSERT_NOW(a_occ_order, w_occ[MAX_VERTICES-1], w_occ[0], "last slot occupied while slot zero is empty")

    // A token leaving the chain while it moves lands in the result register.
    `VID_ASSERT_NEXT(a_tail_lands, w_tok[MAX_VERTICES].valid && w_adv, o_out_valid, "tail token lost at result register")

endmodule

`default_nettype wire
